// ===== rtl/ntab_pkg.sv =====
package ntab_pkg;

	typedef struct packed {
		logic        mode;
		logic [7:0]  sender_id;
		logic [7:0]  sender_distance;
		logic [7:0]  sender_neighbors;
		logic [31:0] now_tick;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  slot_written;
		logic [3:0]  neighbor_count;
		logic [3:0]  removed_count;
		logic [7:0]  wall_distance;
		logic [31:0] wall_seen_tick;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] tick;
		logic [7:0]  distance;
		logic [7:0]  neighbor_count;
	} entry_t;

	localparam logic [2:0] ACT_REFRESH = 3'd0;
	localparam logic [2:0] ACT_INSERT  = 3'd1;
	localparam logic [2:0] ACT_FULL    = 3'd2;
	localparam logic [2:0] ACT_WALL    = 3'd3;
	localparam logic [2:0] ACT_SWEEP   = 3'd4;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_ID   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 1'd1;

	localparam logic [7:0]  WALL_ID_RST   = 8'd0;
	localparam logic [31:0] AGE_LIMIT_RST = 32'd32;

endpackage

// ===== rtl/neighbor_table_with_aging_unit.sv =====
// wall message goes straight to the result; other messages search the table, one table read per cycle
// sweep: a read and a check per entry, plus a move step per expired entry, through the single table read port
// one transaction in flight; the next is taken once the result is in the output register
// arst_n clears count, wall registers and configuration; table contents are not cleared
module neighbor_table_with_aging_unit #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ntab_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ntab_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ntab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]         cfg_data
);
	import ntab_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SRCH  = 6'b000010,
		S_SWRD  = 6'b000100,
		S_SWCHK = 6'b001000,
		S_SWMV  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t           state_q;
	in_item_t         in_q;
	logic [7:0]       wall_id_q;
	logic [31:0]      age_limit_q;
	logic [7:0]       wall_dist_q;
	logic [31:0]      wall_tick_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] removed_q;
	logic [IDX_W-1:0] slot_q;
	logic [2:0]       act_q;
	logic             out_valid_q;
	out_item_t        out_q;

	entry_t           mem [TABLE_DEPTH];
	entry_t           rd_data_s1;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic             in_acc;
	logic             out_free;
	logic             hit;
	logic             miss;
	logic             expired;
	logic [31:0]      age;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] k_m1;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] k_idx;
	logic [IDX_W+2:0] slot_ext;
	logic [CNT_W+3:0] count_ext;
	logic [CNT_W+3:0] removed_ext;
	entry_t           msg_entry;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign cnt_m1   = count_q - 1'b1;
	assign k_m1     = k_q - 1'b1;
	assign last_idx = cnt_m1[IDX_W-1:0];
	assign k_idx    = k_m1[IDX_W-1:0];

	assign hit     = chk_s1 && (rd_data_s1.id == in_q.sender_id);
	assign miss    = !hit && (ptr_q >= count_q);
	assign age     = in_q.now_tick - rd_data_s1.tick;
	assign expired = age > age_limit_q;

	assign msg_entry = '{id: in_q.sender_id, tick: in_q.now_tick,
		distance: in_q.sender_distance, neighbor_count: in_q.sender_neighbors};

	assign slot_ext    = {3'b000, slot_q};
	assign count_ext   = {4'b0000, count_q};
	assign removed_ext = {4'b0000, removed_q};

	// table port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = msg_entry;
		case (state_q)
			S_SRCH: begin
				rd_en = ptr_q < count_q;
				if (hit) begin
					wr_en = 1'b1;
				end else if (miss) begin
					wr_en   = 1'b1;
					wr_addr = (count_q < DEPTH_C) ? count_q[IDX_W-1:0] : LAST_SLOT;
				end
			end
			S_SWRD: begin
				rd_en   = (k_q != '0);
				rd_addr = k_idx;
			end
			S_SWCHK: begin
				rd_en   = expired && (k_idx != last_idx);
				rd_addr = last_idx;
			end
			S_SWMV: begin
				wr_en   = 1'b1;
				wr_addr = k_idx;
				wr_data = rd_data_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (in_acc) begin
			in_q <= in_data;
		end
		if (state_q == S_SRCH) begin
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if ((state_q == S_DONE) && out_free) begin
			out_q <= '{action: act_q, slot_written: slot_ext[2:0],
				neighbor_count: count_ext[3:0], removed_count: removed_ext[3:0],
				wall_distance: wall_dist_q, wall_seen_tick: wall_tick_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wall_id_q   <= WALL_ID_RST;
			age_limit_q <= AGE_LIMIT_RST;
			wall_dist_q <= '0;
			wall_tick_q <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
			removed_q   <= '0;
			slot_q      <= '0;
			act_q       <= ACT_REFRESH;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WALL_ID:   wall_id_q   <= cfg_data[7:0];
					REG_AGE_LIMIT: age_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						removed_q <= '0;
						slot_q    <= '0;
						if (in_data.mode) begin
							k_q     <= count_q;
							state_q <= S_SWRD;
						end else if (in_data.sender_id == wall_id_q) begin
							wall_dist_q <= in_data.sender_distance;
							wall_tick_q <= in_data.now_tick;
							act_q       <= ACT_WALL;
							state_q     <= S_DONE;
						end else begin
							ptr_q   <= '0;
							chk_s1  <= 1'b0;
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					chk_s1 <= rd_en;
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit) begin
						act_q   <= ACT_REFRESH;
						slot_q  <= idx_s1;
						state_q <= S_DONE;
					end else if (miss) begin
						if (count_q < DEPTH_C) begin
							act_q   <= ACT_INSERT;
							slot_q  <= count_q[IDX_W-1:0];
							count_q <= count_q + 1'b1;
						end else begin
							act_q  <= ACT_FULL;
							slot_q <= LAST_SLOT;
						end
						state_q <= S_DONE;
					end
				end
				S_SWRD: begin
					if (k_q == '0) begin
						act_q   <= ACT_SWEEP;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SWCHK;
					end
				end
				S_SWCHK: begin
					if (expired) begin
						removed_q <= removed_q + 1'b1;
						if (k_idx != last_idx) begin
							state_q <= S_SWMV;
						end else begin
							count_q <= cnt_m1;
							k_q     <= k_m1;
							state_q <= S_SWRD;
						end
					end else begin
						k_q     <= k_m1;
						state_q <= S_SWRD;
					end
				end
				S_SWMV: begin
					count_q <= cnt_m1;
					k_q     <= k_m1;
					state_q <= S_SWRD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("neighbor count above table depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_addr < count_q))
		else $error("table read beyond valid entries");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (state_q == S_SWMV)) |-> (wr_addr < last_idx))
		else $error("sweep move targets the last entry or beyond");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import ntab_pkg::*;

	localparam int DEPTH = 8;
	localparam int POOL_SIZE = 12;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	entry_t      model_table [DEPTH] = '{default: '0};
	int          model_count = 0;
	logic [7:0]  model_wall_dist = '0;
	logic [31:0] model_wall_tick = '0;
	logic [7:0]  model_wall_id = WALL_ID_RST;
	logic [31:0] model_age_limit = AGE_LIMIT_RST;

	out_item_t   expected_results [$];
	int          error_count = 0;
	int          quiet_cycles = 0;
	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;
	int          rx_hold_request = 0;
	int          rx_hold_left = 0;
	logic [31:0] tick_now = '0;
	logic [7:0]  id_pool [POOL_SIZE];

	neighbor_table_with_aging_unit #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic out_item_t predict_table_step(in_item_t item);
		out_item_t   res;
		int          slot;
		int          removed;
		int          idx;
		bit          hit;
		logic [31:0] age;
		res = '0;
		slot = 0;
		removed = 0;
		if (item.mode == 1'b0) begin
			if (item.sender_id == model_wall_id) begin
				model_wall_dist = item.sender_distance;
				model_wall_tick = item.now_tick;
				res.action = ACT_WALL;
			end else begin
				idx = 0;
				hit = 1'b0;
				while (idx < model_count && !hit) begin
					if (model_table[idx].id == item.sender_id)
						hit = 1'b1;
					else
						idx++;
				end
				if (hit) begin
					res.action = ACT_REFRESH;
				end else if (model_count < DEPTH) begin
					idx = model_count;
					model_count++;
					res.action = ACT_INSERT;
				end else begin
					idx = DEPTH - 1;
					res.action = ACT_FULL;
				end
				model_table[idx].id = item.sender_id;
				model_table[idx].tick = item.now_tick;
				model_table[idx].distance = item.sender_distance;
				model_table[idx].neighbor_count = item.sender_neighbors;
				slot = idx;
			end
		end else begin
			// walk down; an expired entry takes the current last one
			for (int k = model_count; k > 0; k--) begin
				age = item.now_tick - model_table[k-1].tick;
				if (age > model_age_limit) begin
					model_table[k-1] = model_table[model_count-1];
					model_count--;
					removed++;
				end
			end
			res.action = ACT_SWEEP;
		end
		res.slot_written = slot[2:0];
		res.neighbor_count = model_count[3:0];
		res.removed_count = removed[3:0];
		res.wall_distance = model_wall_dist;
		res.wall_seen_tick = model_wall_tick;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s expected %0d actual %0d", name, exp_v, got_v);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		out_item_t exp_res;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing pending");
					error_count++;
				end else begin
					exp_res = expected_results.pop_front();
					check_field("action", exp_res.action, out_data.action);
					check_field("slot_written", exp_res.slot_written, out_data.slot_written);
					check_field("neighbor_count", exp_res.neighbor_count, out_data.neighbor_count);
					check_field("removed_count", exp_res.removed_count, out_data.removed_count);
					check_field("wall_distance", exp_res.wall_distance, out_data.wall_distance);
					check_field("wall_seen_tick", exp_res.wall_seen_tick, out_data.wall_seen_tick);
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_table_step(in_data));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WALL_ID:   model_wall_id = cfg_data[7:0];
					REG_AGE_LIMIT: model_age_limit = cfg_data;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[neighbor_table_with_aging_unit] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (rx_hold_request != 0) begin
			rx_hold_left = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			out_stall <= rx_idle_en && ($urandom_range(99) < 36);
		end
	end

	task automatic send_item(in_item_t item);
		while (tx_idle_en && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t message(logic [7:0] id, logic [7:0] distance,
			logic [7:0] nbrs, logic [31:0] tick);
		in_item_t item;
		item.mode = 1'b0;
		item.sender_id = id;
		item.sender_distance = distance;
		item.sender_neighbors = nbrs;
		item.now_tick = tick;
		return item;
	endfunction

	function automatic in_item_t sweep(logic [31:0] tick);
		in_item_t item;
		item = '0;
		item.mode = 1'b1;
		item.sender_id = 8'($urandom);
		item.sender_distance = 8'($urandom);
		item.sender_neighbors = 8'($urandom);
		item.now_tick = tick;
		return item;
	endfunction

	function automatic in_item_t random_item();
		in_item_t item;
		int       roll;
		roll = $urandom_range(99);
		tick_now += $urandom_range(0, 6);
		item = message(id_pool[$urandom_range(POOL_SIZE-1)], 8'($urandom), 8'($urandom),
			tick_now);
		if (roll < 15) begin
			item.mode = 1'b1;
		end else if (roll < 25) begin
			item.sender_id = model_wall_id;
		end else if (roll < 30) begin
			// noise: anything the fields allow
			item.mode = 1'($urandom);
			item.sender_id = 8'($urandom);
			item.now_tick = $urandom;
		end
		return item;
	endfunction

	task automatic new_id_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = 8'($urandom);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			send_item(random_item());
	endtask

	task automatic test_directed();
		send_item(sweep(32'd50));
		send_item(message(8'd0, 8'd255, 8'd255, 32'hFFFF_FFFF));
		for (int k = 1; k <= DEPTH; k++)
			send_item(message(k[7:0], (k % 2) ? 8'd0 : 8'd255, (k % 2) ? 8'd255 : 8'd0,
				32'd100 + k));
		send_item(message(8'd9, 8'd77, 8'd3, 32'd110));
		send_item(message(8'd3, 8'd12, 8'd4, 32'd120));
		// partial expiry with moved entries, then age equal to limit
		send_item(sweep(32'd140));
		send_item(sweep(32'd152));
		send_item(message(8'd255, 8'd1, 8'd2, 32'd160));
		// tick wrap around zero
		send_item(message(8'd50, 8'd5, 8'd6, 32'hFFFF_FFF0));
		send_item(sweep(32'h0000_0010));
		send_item(sweep(32'h0000_0011));
		send_item(message(8'd0, 8'd0, 8'd0, 32'd0));
		drain_results();
	endtask

	task automatic test_register_extremes();
		new_id_pool();
		write_reg(REG_WALL_ID, 32'd255);
		write_reg(REG_AGE_LIMIT, 32'd0);
		tick_now = $urandom;
		run_random(150);
		drain_results();
		new_id_pool();
		write_reg(REG_WALL_ID, 32'd0);
		write_reg(REG_AGE_LIMIT, 32'hFFFF_FFFF);
		tick_now = 32'hFFFF_FF00;
		run_random(150);
		drain_results();
		write_reg(REG_AGE_LIMIT, AGE_LIMIT_RST);
		tick_now = 32'hFFFF_FFC0;
		run_random(150);
		drain_results();
	endtask

	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_hold_request = HOLD_CYCLES;
		run_random(30);
		drain_results();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			new_id_pool();
			write_reg(REG_WALL_ID, $urandom);
			write_reg(REG_AGE_LIMIT, $urandom_range(4, 64));
			tick_now = $urandom;
			tx_idle_en = (phase != 2);
			rx_idle_en = (phase != 2);
			run_random(320);
			drain_results();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		drain_results();
		if (error_count == 0)
			$display("[neighbor_table_with_aging_unit] OK");
		else
			$display("[neighbor_table_with_aging_unit] ERROR");
		$finish;
	end

endmodule
